FILE: sv/linear_probe_hash_table_top_assert.svh
// Assertion macros used by the linear probe hash table datapath.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define LPHT_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPHT_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lpht_pkg.sv
package lpht_pkg;

    localparam int DATA_W = 64;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] FILL_RESET = 11'd768;

    localparam logic [OP_W-1:0] OP_GET  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUT  = 3'd1;
    localparam logic [OP_W-1:0] OP_REPL = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

    localparam logic [1:0] FLAG_LIVE = 2'b01;
    localparam logic [1:0] FLAG_TOMB = 2'b10;

    typedef struct packed {
        logic [DATA_W-1:0] hash_high;
        logic [DATA_W-1:0] hash_low;
        logic [DATA_W-1:0] value;
        logic [1:0]        flags;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic clear;
        logic load;
        logic probe;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic reject;
        logic done;
        logic out_free;
    } t_stat;

endpackage

FILE: sv/lpht_if.sv
interface lpht_in_if import lpht_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] key_hash_low;
    logic [DATA_W-1:0] key_hash_high;
    logic [DATA_W-1:0] item_value;

    modport source (output valid, op, key_hash_low, key_hash_high, item_value, input ready);
    modport sink (input valid, op, key_hash_low, key_hash_high, item_value, output ready);
endinterface

interface lpht_out_if import lpht_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] old_value;
    logic              found;
    logic [CNT_W-1:0]  live_count;
    logic [ST_W-1:0]   status;

    modport source (output valid, old_value, found, live_count, status, input ready);
    modport sink (input valid, old_value, found, live_count, status, output ready);
endinterface

FILE: sv/lpht_ram.sv
module lpht_ram #(
    parameter int WIDTH = 194,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

FILE: sv/lpht_ctrl.sv
module lpht_ctrl import lpht_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_PROBE  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.reject ? S_FINISH : S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_stat.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/lpht_dpath.sv
`include "linear_probe_hash_table_top_assert.svh"

module lpht_dpath import lpht_pkg::*; #(
    parameter int SLOTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CNT_W-1:0]  i_cfg_wr_data,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [OP_W-1:0]   i_op,
    input  logic [DATA_W-1:0] i_key_hash_low,
    input  logic [DATA_W-1:0] i_key_hash_high,
    input  logic [DATA_W-1:0] i_item_value,
    output logic              o_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_old_value,
    output logic              o_found,
    output logic [CNT_W-1:0]  o_live_count,
    output logic [ST_W-1:0]   o_status
);

    localparam int IDX_W = $clog2(SLOTS);

    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_hlo;
    logic [DATA_W-1:0] r_hhi;
    logic [DATA_W-1:0] r_val;
    logic [IDX_W-1:0]  r_bix;
    logic [IDX_W-1:0]  r_pcnt;
    logic [IDX_W-1:0]  r_clr_idx;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_resv;
    logic [CNT_W-1:0]  r_live;
    logic [DATA_W-1:0] r_res_old;
    logic              r_res_found;
    logic [ST_W-1:0]   r_res_status;
    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_old;
    logic              r_o_found;
    logic [CNT_W-1:0]  r_o_live;
    logic [ST_W-1:0]   r_o_status;

    logic [ENTRY_W-1:0] w_rd_raw;
    t_entry             w_rd;
    t_entry             w_wr;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [IDX_W-1:0]   w_rd_addr;
    logic [IDX_W-1:0]   w_bix_inc;
    logic               w_zero;
    logic               w_match;
    logic               w_empty;
    logic               w_live;
    logic               w_exhaust;
    logic               w_stop;
    logic               w_ins;
    logic               w_claim_ok;
    logic               w_claim;
    logic               w_live_inc;
    logic               w_live_dec;
    logic               w_found;
    logic [DATA_W-1:0]  w_old;
    logic [ST_W-1:0]    w_res_status;

    assign w_rd      = t_entry'(w_rd_raw);
    assign w_bix_inc = r_bix + IDX_W'(1);
    assign w_zero    = (i_key_hash_low == '0) && (i_key_hash_high == '0);
    assign w_match   = (w_rd.hash_low == r_hlo) && (w_rd.hash_high == r_hhi);
    assign w_empty   = (w_rd.hash_low == '0) && (w_rd.hash_high == '0);
    assign w_live    = |(w_rd.flags & FLAG_LIVE);
    assign w_exhaust = !w_match && !w_empty && (r_pcnt == IDX_W'(SLOTS - 1));
    assign w_stop    = w_match || w_empty || w_exhaust;
    assign w_ins     = r_op inside {OP_PUT, OP_ADD};
    assign w_claim_ok = ({1'b0, r_resv} + (CNT_W + 1)'(1)) < {1'b0, r_fill};
    assign w_found   = w_match && w_live;
    assign w_old     = w_found ? w_rd.value : '0;

    assign w_rd_addr = i_cmd.load ? i_key_hash_low[IDX_W-1:0] : w_bix_inc;
    assign w_wr_addr = i_cmd.clear ? r_clr_idx : r_bix;

    assign o_stat.clr_last = (r_clr_idx == IDX_W'(SLOTS - 1));
    assign o_stat.reject   = w_zero || (i_op > OP_DEL);
    assign o_stat.done     = w_stop;
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    always_comb begin
        w_wr_en      = 1'b0;
        w_wr         = '{hash_high: r_hhi, hash_low: r_hlo, value: r_val, flags: FLAG_LIVE};
        w_claim      = 1'b0;
        w_live_inc   = 1'b0;
        w_live_dec   = 1'b0;
        w_res_status = ST_DONE;
        if (i_cmd.clear) begin
            w_wr_en = 1'b1;
            w_wr    = '0;
        end else if (i_cmd.probe) begin
            if (w_match) begin
                case (r_op)
                    OP_PUT: begin
                        w_wr_en    = 1'b1;
                        w_live_inc = !w_live;
                    end
                    OP_REPL: begin
                        w_wr_en = w_live;
                    end
                    OP_ADD: begin
                        w_wr_en    = !w_live;
                        w_live_inc = !w_live;
                    end
                    OP_DEL: begin
                        w_wr_en    = w_live;
                        w_live_dec = w_live;
                        w_wr.value = w_rd.value;
                        w_wr.flags = FLAG_TOMB;
                    end
                    default: begin
                        w_wr_en = 1'b0;
                    end
                endcase
            end else if (w_empty) begin
                if (w_ins) begin
                    if (w_claim_ok) begin
                        w_wr_en    = 1'b1;
                        w_claim    = 1'b1;
                        w_live_inc = 1'b1;
                    end else begin
                        w_res_status = ST_FULL;
                    end
                end
            end else if (w_exhaust && w_ins) begin
                w_res_status = ST_FULL;
            end
        end
    end

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= FILL_RESET;
            r_resv    <= '0;
            r_live    <= '0;
            r_clr_idx <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fill <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (w_claim) begin
                r_resv <= r_resv + CNT_W'(1);
            end
            if (w_live_inc) begin
                r_live <= r_live + CNT_W'(1);
            end else if (w_live_dec) begin
                r_live <= r_live - CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_op;
            r_hlo        <= i_key_hash_low;
            r_hhi        <= i_key_hash_high;
            r_val        <= i_item_value;
            r_bix        <= i_key_hash_low[IDX_W-1:0];
            r_pcnt       <= '0;
            r_res_old    <= '0;
            r_res_found  <= 1'b0;
            r_res_status <= w_zero ? ST_ZERO : ST_DONE;
        end else if (i_cmd.probe) begin
            if (w_stop) begin
                r_res_old    <= w_old;
                r_res_found  <= w_found;
                r_res_status <= w_res_status;
            end else begin
                r_bix  <= w_bix_inc;
                r_pcnt <= r_pcnt + IDX_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_o_old    <= r_res_old;
            r_o_found  <= r_res_found;
            r_o_live   <= r_live;
            r_o_status <= r_res_status;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_old_value  = r_o_old;
    assign o_found      = r_o_found;
    assign o_live_count = r_o_live;
    assign o_status     = r_o_status;

    `LPHT_AST_IMP(a_live_le_resv, i_clk, i_rst_n, 1'b1, r_live <= r_resv, "live above reserved")
    `LPHT_AST_IMP(a_wr_hash_set, i_clk, i_rst_n, w_wr_en && !i_cmd.clear, w_wr.hash_low != '0 || w_wr.hash_high != '0, "zero key written")
    `LPHT_AST_IMP(a_out_free, i_clk, i_rst_n, i_cmd.out_load, !r_o_valid || i_out_ready, "result overwritten")
    `LPHT_AST_NXT(a_claim_cnt, i_clk, i_rst_n, w_claim, r_resv == $past(r_resv) + CNT_W'(1), "claim not counted")

endmodule

FILE: sv/linear_probe_hash_table_top.sv
// Linear probe hash table keyed by a 128-bit hash.
// i_item (valid/ready) takes one operation: op, key_hash_low, key_hash_high,
// item_value. o_result (valid/ready) returns old_value, found, live_count and
// status for every accepted item, in order. i_cfg_wr_en/i_cfg_wr_data write
// the 11-bit fill limit (reset 768); the user must write it only while the
// block is idle; the block does not enforce this. Buckets sit in one RAM with
// registered read; a single probe sequencer reads one bucket per cycle. An
// accepted item is loaded and probed until a key match, an empty bucket or a
// pass over every bucket, then its result is loaded into the result register;
// the next item is accepted only after that load. Zero-hash and undefined ops
// skip the probe. After reset the table runs a clearing pass over all SLOTS
// buckets, one bucket per cycle, with ready low; fill limit writes are still
// taken. The result register holds while o_result.ready is low; one further
// item is accepted and worked, then held until the register frees.
module linear_probe_hash_table_top import lpht_pkg::*; #(
    parameter int SLOTS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data,
    lpht_in_if.sink          i_item,
    lpht_out_if.source       o_result
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;

    assign i_item.ready = w_ready;

    lpht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (w_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    lpht_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_op            (i_item.op),
        .i_key_hash_low  (i_item.key_hash_low),
        .i_key_hash_high (i_item.key_hash_high),
        .i_item_value    (i_item.item_value),
        .o_valid         (o_result.valid),
        .i_out_ready     (o_result.ready),
        .o_old_value     (o_result.old_value),
        .o_found         (o_result.found),
        .o_live_count    (o_result.live_count),
        .o_status        (o_result.status)
    );

endmodule

FILE: verif/tb.sv
module tb;
    import lpht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS  = 1024;
    localparam int POOL_N = 64;
    localparam int DIR_N  = 26;

    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam logic [DATA_W-1:0] Z64   = 64'h0;
    localparam logic [DATA_W-1:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] V_A   = 64'h5555_5555_5555_5555;
    localparam logic [DATA_W-1:0] V_B   = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [DATA_W-1:0] V_C   = 64'h0000_0001_DEAD_BEEF;
    localparam logic [DATA_W-1:0] KA_LO = 64'h0123_4567_89AB_C805;
    localparam logic [DATA_W-1:0] KA_HI = 64'hFEDC_BA98_7654_3210;
    localparam logic [DATA_W-1:0] KB_LO = 64'h0000_0000_0000_0222;
    localparam logic [DATA_W-1:0] KB_HI = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] ONE64 = 64'h1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] hash_low;
        logic [DATA_W-1:0] hash_high;
        logic [DATA_W-1:0] value;
    } t_hash_op;

    typedef struct packed {
        logic [DATA_W-1:0] old_value;
        logic              found;
        logic [CNT_W-1:0]  live_count;
        logic [ST_W-1:0]   status;
    } t_lookup_result;

    typedef struct packed {
        t_hash_op       item;
        logic           typed;
        t_lookup_result res;
    } t_dir_row;

    localparam t_lookup_result NO_RES = '0;

    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{'{OP_GET,   KA_LO, KA_HI, Z64},  1'b1, '{Z64, 1'b0, 11'd0, ST_DONE}},
        '{'{OP_PUT,   Z64,   Z64,   ONES}, 1'b1, '{Z64, 1'b0, 11'd0, ST_ZERO}},
        '{'{OP_ADD,   Z64,   Z64,   V_A},  1'b1, '{Z64, 1'b0, 11'd0, ST_ZERO}},
        '{'{OP_DEL,   Z64,   Z64,   Z64},  1'b1, '{Z64, 1'b0, 11'd0, ST_ZERO}},
        '{'{OP_RSVD5, KA_LO, KA_HI, ONES}, 1'b1, '{Z64, 1'b0, 11'd0, ST_DONE}},
        '{'{OP_RSVD6, KA_LO, KA_HI, V_A},  1'b1, '{Z64, 1'b0, 11'd0, ST_DONE}},
        '{'{OP_RSVD7, Z64,   Z64,   V_B},  1'b1, '{Z64, 1'b0, 11'd0, ST_ZERO}},
        '{'{OP_REPL,  KA_LO, KA_HI, V_A},  1'b1, '{Z64, 1'b0, 11'd0, ST_DONE}},
        '{'{OP_DEL,   KA_LO, KA_HI, Z64},  1'b1, '{Z64, 1'b0, 11'd0, ST_DONE}},
        '{'{OP_PUT,   KA_LO, KA_HI, ONES}, 1'b0, NO_RES},
        '{'{OP_PUT,   ONES,  ONES,  Z64},  1'b0, NO_RES},
        '{'{OP_PUT,   Z64,   ONE64, V_A},  1'b0, NO_RES},
        '{'{OP_PUT,   ONES,  Z64,   V_B},  1'b0, NO_RES},
        '{'{OP_GET,   ONES,  Z64,   Z64},  1'b0, NO_RES},
        '{'{OP_PUT,   KA_LO, KA_HI, V_C},  1'b0, NO_RES},
        '{'{OP_REPL,  KA_LO, KA_HI, V_A},  1'b0, NO_RES},
        '{'{OP_ADD,   KA_LO, KA_HI, V_B},  1'b0, NO_RES},
        '{'{OP_DEL,   KA_LO, KA_HI, Z64},  1'b0, NO_RES},
        '{'{OP_GET,   KA_LO, KA_HI, Z64},  1'b0, NO_RES},
        '{'{OP_REPL,  KA_LO, KA_HI, V_C},  1'b0, NO_RES},
        '{'{OP_ADD,   KA_LO, KA_HI, ONES}, 1'b0, NO_RES},
        '{'{OP_DEL,   ONES,  ONES,  Z64},  1'b0, NO_RES},
        '{'{OP_PUT,   ONES,  ONES,  V_C},  1'b0, NO_RES},
        '{'{OP_DEL,   Z64,   ONE64, Z64},  1'b0, NO_RES},
        '{'{OP_GET,   ONES,  Z64,   Z64},  1'b0, NO_RES},
        '{'{OP_ADD,   KB_LO, KB_HI, V_B},  1'b0, NO_RES}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CNT_W-1:0] i_cfg_wr_data;

    lpht_in_if  item_if ();
    lpht_out_if result_if ();

    linear_probe_hash_table_top #(
        .SLOTS (SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (item_if),
        .o_result      (result_if)
    );

    logic [DATA_W-1:0] slot_lo    [SLOTS];
    logic [DATA_W-1:0] slot_hi    [SLOTS];
    logic [DATA_W-1:0] slot_val   [SLOTS];
    logic [1:0]        slot_flags [SLOTS];
    int unsigned       claimed_cnt;
    int unsigned       live_cnt;
    logic [CNT_W-1:0]  fill_lim;

    logic [DATA_W-1:0] pool_lo [POOL_N];
    logic [DATA_W-1:0] pool_hi [POOL_N];

    t_lookup_result pending_results [$];

    int unsigned fail_cnt;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned full_cnt;
    int unsigned zero_cnt;
    int unsigned hit_cnt;
    int unsigned limit_cnt;
    int unsigned burst_left;
    bit          steady;

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_lookup_result apply_op(input t_hash_op it);
        t_lookup_result r;
        int unsigned    b;
        int unsigned    steps;
        logic           stop;
        logic           live;
        r = '0;
        stop = 1'b0;
        if (it.hash_low == '0 && it.hash_high == '0) begin
            r.status = ST_ZERO;
            stop = 1'b1;
        end
        if (it.op > OP_DEL) begin
            stop = 1'b1;
        end
        b = 32'(it.hash_low % SLOTS);
        steps = 0;
        while (!stop && steps < SLOTS) begin
            if (slot_lo[b] == it.hash_low && slot_hi[b] == it.hash_high) begin
                live = (slot_flags[b] & FLAG_LIVE) != '0;
                stop = 1'b1;
                if (live) begin
                    r.found = 1'b1;
                    r.old_value = slot_val[b];
                end
                case (it.op)
                    OP_PUT: begin
                        if (!live) begin
                            slot_flags[b] = FLAG_LIVE;
                            live_cnt++;
                        end
                        slot_val[b] = it.value;
                    end
                    OP_REPL: begin
                        if (live) slot_val[b] = it.value;
                    end
                    OP_ADD: begin
                        if (!live) begin
                            slot_val[b] = it.value;
                            slot_flags[b] = FLAG_LIVE;
                            live_cnt++;
                        end
                    end
                    OP_DEL: begin
                        if (live) begin
                            slot_flags[b] = FLAG_TOMB;
                            live_cnt--;
                        end
                    end
                    default: ;
                endcase
            end else if (slot_lo[b] == '0 && slot_hi[b] == '0) begin
                stop = 1'b1;
                if (it.op == OP_PUT || it.op == OP_ADD) begin
                    if (claimed_cnt + 1 >= fill_lim) begin
                        r.status = ST_FULL;
                    end else begin
                        claimed_cnt++;
                        live_cnt++;
                        slot_lo[b] = it.hash_low;
                        slot_hi[b] = it.hash_high;
                        slot_val[b] = it.value;
                        slot_flags[b] = FLAG_LIVE;
                    end
                end
            end else begin
                b = (b + 1) % SLOTS;
                steps++;
            end
        end
        if (!stop && (it.op == OP_PUT || it.op == OP_ADD)) begin
            r.status = ST_FULL;
        end
        r.live_count = live_cnt[CNT_W-1:0];
        return r;
    endfunction

    function automatic t_hash_op rand_item(input int unsigned fresh_pct);
        t_hash_op    it;
        int unsigned r;
        int unsigned k;
        int unsigned w;
        int unsigned v;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, POOL_N - 1);
        w = $urandom_range(0, 99);
        v = $urandom_range(0, 15);
        it.hash_low = pool_lo[k];
        it.hash_high = pool_hi[k];
        if (w < 20) it.op = OP_GET;
        else if (w < 45) it.op = OP_PUT;
        else if (w < 60) it.op = OP_REPL;
        else if (w < 80) it.op = OP_ADD;
        else it.op = OP_DEL;
        it.value = (v == 0) ? Z64 : (v == 1) ? ONES : rand64();
        if (r < 4) begin
            it.hash_low = '0;
            it.hash_high = '0;
            it.op = OP_W'($urandom);
        end else if (r < 8) begin
            case ($urandom_range(0, 2))
                0: it.op = OP_RSVD5;
                1: it.op = OP_RSVD6;
                default: it.op = OP_RSVD7;
            endcase
        end else if (r < 8 + fresh_pct) begin
            it.hash_low = rand64();
            it.hash_high = rand64();
        end
        return it;
    endfunction

    task automatic issue(input t_hash_op it, input bit typed, input t_lookup_result typed_res);
        int unsigned    gap;
        t_lookup_result r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item_if.valid         <= 1'b1;
        item_if.op            <= it.op;
        item_if.key_hash_low  <= it.hash_low;
        item_if.key_hash_high <= it.hash_high;
        item_if.item_value    <= it.value;
        do @(posedge i_clk); while (!item_if.ready);
        r = apply_op(it);
        items_sent++;
        if (r.status == ST_FULL) full_cnt++;
        if (r.status == ST_ZERO) zero_cnt++;
        if (r.found) hit_cnt++;
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_fill(input logic [CNT_W-1:0] lim);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= lim;
        @(posedge i_clk);
        fill_lim = lim;
        limit_cnt++;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count, input int unsigned fresh_pct);
        steady = ($urandom_range(0, 3) == 0);
        repeat (count) issue(rand_item(fresh_pct), 1'b0, NO_RES);
    endtask

    task automatic fill_every_bucket();
        int unsigned b;
        t_hash_op    it;
        steady = 1'b0;
        while (claimed_cnt < SLOTS) begin
            b = $urandom_range(0, SLOTS - 1);
            while (slot_lo[b] != '0 || slot_hi[b] != '0) b = (b + 1) % SLOTS;
            it.op        = OP_PUT;
            it.hash_low  = (rand64() & ~(DATA_W'(SLOTS - 1))) | DATA_W'(b);
            it.hash_high = rand64() | ONE64;
            it.value     = rand64();
            issue(it, 1'b0, NO_RES);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("linear_probe_hash_table_top regression: fail");
        $finish;
    end

    initial begin
        int unsigned stall_mode;
        int unsigned span;
        int unsigned hold;
        logic        level;
        result_if.ready <= 1'b0;
        hold = 0;
        level = 1'b0;
        forever begin
            stall_mode = $urandom_range(0, 3);
            span = $urandom_range(50, 300);
            repeat (span) begin
                @(posedge i_clk);
                case (stall_mode)
                    0: level = 1'b1;
                    1: level = 1'($urandom_range(0, 1));
                    2: level = ($urandom_range(0, 6) != 0);
                    default: begin
                        if (hold == 0) begin
                            level = 1'($urandom_range(0, 1));
                            hold = $urandom_range(1, 25);
                        end else begin
                            hold--;
                        end
                    end
                endcase
                result_if.ready <= level;
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding");
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (result_if.old_value !== want.old_value) begin
                    $error("old_value: expected %h, got %h", want.old_value,
                           result_if.old_value);
                    fail_cnt++;
                end
                if (result_if.found !== want.found) begin
                    $error("found: expected %b, got %b", want.found, result_if.found);
                    fail_cnt++;
                end
                if (result_if.live_count !== want.live_count) begin
                    $error("live_count: expected %0d, got %0d", want.live_count,
                           result_if.live_count);
                    fail_cnt++;
                end
                if (result_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, result_if.status);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        int unsigned k;
        logic [DATA_W-1:0] base;
        i_rst_n               <= 1'b0;
        i_cfg_wr_en           <= 1'b0;
        i_cfg_wr_data         <= '0;
        item_if.valid         <= 1'b0;
        item_if.op            <= OP_GET;
        item_if.key_hash_low  <= '0;
        item_if.key_hash_high <= '0;
        item_if.item_value    <= '0;
        for (k = 0; k < SLOTS; k++) begin
            slot_lo[k] = '0;
            slot_hi[k] = '0;
            slot_val[k] = '0;
            slot_flags[k] = '0;
        end
        claimed_cnt = 0;
        live_cnt = 0;
        fill_lim = FILL_RESET;
        fail_cnt = 0;
        items_sent = 0;
        results_seen = 0;
        full_cnt = 0;
        zero_cnt = 0;
        hit_cnt = 0;
        limit_cnt = 0;
        burst_left = 0;
        steady = 1'b0;

        // cluster a quarter of the keys around the wrap point, share low words on another
        for (k = 0; k < POOL_N; k++) begin
            base = rand64() & ~(DATA_W'(SLOTS - 1));
            case (k % 4)
                0: pool_lo[k] = base | DATA_W'((SLOTS - 6 + $urandom_range(0, 9)) % SLOTS);
                1: pool_lo[k] = pool_lo[k - 1];
                default: pool_lo[k] = rand64();
            endcase
            pool_hi[k] = rand64();
            if (pool_lo[k] == '0 && pool_hi[k] == '0) pool_hi[k] = ONE64;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_N; k++) begin
            issue(DIR_ROWS[k].item, DIR_ROWS[k].typed, DIR_ROWS[k].res);
        end
        drain();
        run_random(200, 10);
        drain();
        set_fill(CNT_W'(claimed_cnt + $urandom_range(2, 6)));
        run_random(100, 10);
        drain();
        set_fill('0);
        run_random(60, 20);
        drain();
        set_fill(CNT_W'(1));
        run_random(60, 20);
        drain();
        set_fill(CNT_W'(SLOTS));
        run_random(120, 10);
        drain();
        set_fill('1);
        run_random(40, 10);
        fill_every_bucket();
        run_random(60, 45);
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d items and %0d results over %0d fill limits", items_sent,
                 results_seen, limit_cnt + 1);
        $display("hits %0d, table full %0d, zero hash %0d, final live %0d of %0d buckets",
                 hit_cnt, full_cnt, zero_cnt, live_cnt, claimed_cnt);
        if (fail_cnt == 0) begin
            $display("linear_probe_hash_table_top regression: pass");
        end else begin
            $display("linear_probe_hash_table_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: linear_probe_hash_table_top.f
+incdir+sv
sv/lpht_pkg.sv
sv/lpht_if.sv
sv/lpht_ram.sv
sv/lpht_ctrl.sv
sv/lpht_dpath.sv
sv/linear_probe_hash_table_top.sv
verif/tb.sv
